@@ hdl/ins_pkg.sv @@
// Shared types and constants for the insertion sorter.
package ins_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int DATA_W = 32;

	typedef enum logic [0:0] {
		ST_FILL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic one;
	} status_t;

endpackage

@@ hdl/ins_datapath.sv @@
// Datapath of the insertion sorter: compare-and-shift cell row, fill count and output register.
module ins_datapath #(
	parameter int DEPTH = ins_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ins_pkg::cmd_t                     cmd,
	output ins_pkg::status_t                  status,
	input  logic signed [ins_pkg::DATA_W-1:0] value,
	output logic signed [ins_pkg::DATA_W-1:0] sorted_value,
	output logic                              last_out
);

	localparam int CW = $clog2(DEPTH + 1);

	logic signed [ins_pkg::DATA_W-1:0] store_q [DEPTH];
	logic signed [ins_pkg::DATA_W-1:0] store_d [DEPTH];
	logic [DEPTH-1:0]                  gt;
	logic [CW-1:0]                     count_q;
	logic                              full;
	logic signed [ins_pkg::DATA_W-1:0] out_q;
	logic                              out_last_q;

	assign full = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign status.one = (count_q == CW'(1));

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CW'(i) < count_q) && (store_q[i] > value);
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
				store_d[i] = store_q[(i > 0) ? i - 1 : 0];
			end else if (gt[i] || CW'(i) == count_q) begin
				store_d[i] = value;
			end else begin
				store_d[i] = store_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && !full) begin
			for (int i = 0; i < DEPTH; i++) begin
				store_q[i] <= store_d[i];
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				store_q[i] <= store_q[i + 1];
			end
		end
		if (cmd.pop) begin
			out_q <= store_q[0];
			out_last_q <= status.one;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert && !full) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign sorted_value = out_q;
	assign last_out = out_last_q;

endmodule

@@ hdl/ins_ctrl.sv @@
// Controller of the insertion sorter: fill and emit sequencing and output handshake.
module ins_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output ins_pkg::cmd_t    cmd,
	input  ins_pkg::status_t status
);

	ins_pkg::state_t state_q;
	ins_pkg::state_t state_d;
	logic            out_valid_q;
	logic            can_load;

	assign can_load = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ins_pkg::ST_FILL: begin
				if (s_tvalid && s_tlast) begin
					state_d = ins_pkg::ST_EMIT;
				end
			end
			ins_pkg::ST_EMIT: begin
				if (status.empty || (status.one && can_load)) begin
					state_d = ins_pkg::ST_FILL;
				end
			end
			default: state_d = ins_pkg::ST_FILL;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd.insert = 1'b0;
		cmd.pop = 1'b0;
		case (state_q)
			ins_pkg::ST_FILL: begin
				s_tready = 1'b1;
				cmd.insert = s_tvalid;
			end
			ins_pkg::ST_EMIT: begin
				cmd.pop = !status.empty && can_load;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ins_pkg::ST_FILL;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.pop) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

@@ hdl/insertion_sorter.sv @@
// Top level of the insertion sorter.
// Each input transaction carries one signed value; a row of DEPTH compare-and-shift cells
// inserts it into the sorted store, so values stream in at one per cycle while filling.
// A transaction with tlast closes the set: the block then emits the stored values in
// ascending order at one per cycle (as the sink accepts them) by shifting the cell row down,
// marks the largest with tlast, and takes no input until the final value is loaded into the
// output register. Values arriving while DEPTH values are held are dropped; a dropped value
// with tlast still closes the set.
module insertion_sorter #(
	parameter int DEPTH = ins_pkg::DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [ins_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
	input  logic                       s_tlast,  // last_in
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [ins_pkg::DATA_W-1:0] m_tdata,  // [31:0] sorted_value
	output logic                       m_tlast   // last_out
);

	ins_pkg::cmd_t                     cmd;
	ins_pkg::status_t                  status;
	logic signed [ins_pkg::DATA_W-1:0] sorted_value;

	ins_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	ins_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value        (signed'(s_tdata)),
		.sorted_value (sorted_value),
		.last_out     (m_tlast)
	);

	assign m_tdata = unsigned'(sorted_value);

endmodule

@@ tb/sv/insertion_sorter_test.sv @@
// Self-checking testbench for the insertion sorter with a scoreboard and random stream traffic.
module insertion_sorter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = ins_pkg::DEPTH_DEFAULT;
	localparam int DW = ins_pkg::DATA_W;
	localparam int RANDOM_ITEMS = 360;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic signed [DW-1:0] value;
		logic                 last;
	} sorted_item_t;

	class sort_scoreboard;
		logic signed [DW-1:0] held_values[DEPTH];
		int                   held_count;
		sorted_item_t         expected_sorted[$];
		int                   errors;

		function new();
			held_count = 0;
			errors = 0;
		endfunction

		function void note_value(logic signed [DW-1:0] value, logic last);
			int           pos;
			sorted_item_t item;
			if (held_count < DEPTH) begin
				pos = held_count;
				while (pos > 0 && held_values[pos-1] > value) begin
					held_values[pos] = held_values[pos-1];
					pos--;
				end
				held_values[pos] = value;
				held_count++;
			end
			if (last) begin
				for (int k = 0; k < held_count; k++) begin
					item.value = held_values[k];
					item.last = (k == held_count - 1);
					expected_sorted.push_back(item);
				end
				held_count = 0;
			end
		endfunction

		function void check_output(logic signed [DW-1:0] value, logic last);
			sorted_item_t item;
			if (expected_sorted.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual value %0d last %0b",
					$time, value, last);
				errors++;
				return;
			end
			item = expected_sorted.pop_front();
			if (item.value !== value) begin
				$display("%0t: sorted_value mismatch, expected %0d, actual %0d",
					$time, item.value, value);
				errors++;
			end
			if (item.last !== last) begin
				$display("%0t: last_out mismatch, expected %0b, actual %0b",
					$time, item.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_sorted.size();
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [DW-1:0] s_tdata = '0;
	logic          s_tlast = 1'b0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [DW-1:0] m_tdata;
	logic          m_tlast;

	sort_scoreboard board = new();
	bit             hold_request = 1'b0;
	int             items_sent = 0;

	insertion_sorter #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),  // [31:0] value
		.s_tlast(s_tlast),  // last_in
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),  // [31:0] sorted_value
		.m_tlast(m_tlast)   // last_out
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_output($signed(m_tdata), m_tlast);
			if (s_tvalid && s_tready)
				board.note_value($signed(s_tdata), s_tlast);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [DW-1:0] pick_value(int mode);
		int r;
		case (mode)
			0: return $urandom();
			1: return DW'($signed($urandom_range(0, 8)) - 4);
			default: begin
				r = $urandom_range(0, 5);
				case (r)
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					3: return 32'hffff_ffff;
					4: return 32'h8000_0001;
					default: return $urandom();
				endcase
			end
		endcase
	endfunction

	task automatic send_item(logic [DW-1:0] value, logic last, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (items_sent == 120)
			hold_request = 1'b1;
	endtask

	task automatic send_set(int len, int mode, bit burst);
		for (int i = 0; i < len; i++)
			send_item(pick_value(mode), i == len - 1, burst ? 0 : pick_gap());
	endtask

	initial begin
		bit hold_done;
		int r;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					m_tready <= 1'b1;
					repeat (50) @(posedge clk);
				end else if (r < 70) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end else if (r < 95) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int r;
		int len;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(32'h8000_0000, 1'b1, 0);
		send_item(32'h7fff_ffff, 1'b0, 0);
		send_item(32'h8000_0000, 1'b0, 0);
		send_item(32'h0000_0000, 1'b0, 1);
		send_item(32'hffff_ffff, 1'b0, 0);
		send_item(32'h0000_0001, 1'b1, 0);
		// Descending values shift the whole row; the last three arrive with the store full.
		for (int i = 0; i < 19; i++)
			send_item(32'h7fff_ffff - 32'(i * 32'h0700_0000), i == 18, 0);

		while (items_sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				len = $urandom_range(1, DEPTH);
			else if (r < 75)
				len = DEPTH;
			else if (r < 88)
				len = $urandom_range(DEPTH + 1, DEPTH + 6);
			else
				len = $urandom_range(1, 3);
			send_set(len, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
		end
		s_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (board.pending() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, board.pending());
			board.errors++;
		end
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5ms;
		$display("%0t: timeout", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
